@@ rtl/rspu_pkg.sv @@
// ----------------------------------------------------------------------------
// rspu_pkg
// Shared types and constants for the range-sum point-update tree.
// ----------------------------------------------------------------------------
package rspu_pkg;

	// Field widths fixed by the interface
	localparam int IDX_W = 11;
	localparam int SUM_W = 32;

	// Reset value of the element count register
	localparam logic [IDX_W-1:0] RST_COUNT = 11'd1024;

	// Action codes on the request port
	localparam logic ACTION_SET   = 1'b0;
	localparam logic ACTION_QUERY = 1'b1;

	// Classified command passed from front to back
	typedef enum logic [1:0] {
		CMD_SET,
		CMD_QUERY,
		CMD_EMPTY
	} cmd_t;

	// Back-end sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPD,
		ST_QRY,
		ST_OUT
	} state_t;

endpackage

@@ rtl/rspu_front.sv @@
// ----------------------------------------------------------------------------
// rspu_front
// Holds the element count, accepts requests, drops ignored sets, clamps
// query bounds and converts them to tree node pointers.
// ----------------------------------------------------------------------------
module rspu_front #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rspu_pkg::IDX_W-1:0]       cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             action,
	input  logic [rspu_pkg::IDX_W-1:0]       position,
	input  logic signed [rspu_pkg::SUM_W-1:0] value,
	input  logic [rspu_pkg::IDX_W-1:0]       range_low,
	input  logic [rspu_pkg::IDX_W-1:0]       range_high,
	input  logic                             clearing,
	input  logic                             q_full,
	output logic                             push,
	output rspu_pkg::cmd_t                   push_cmd,
	output logic [$clog2(2*MAX_ELEMENTS):0]  push_left,
	output logic [$clog2(2*MAX_ELEMENTS):0]  push_right,
	output logic [rspu_pkg::SUM_W-1:0]       push_value
);

	localparam int NW = $clog2(2*MAX_ELEMENTS);
	localparam int PW = NW + 1;
	localparam int AW = (PW > rspu_pkg::IDX_W + 1) ? PW : rspu_pkg::IDX_W + 1;

	logic [rspu_pkg::IDX_W-1:0] cnt_q;
	logic [AW-1:0] cnt_eff, hi_c, lo_c, left_a, right_a, leaf_a;
	logic set_ok, empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= rspu_pkg::RST_COUNT;
		end else if (cfg_we) begin
			cnt_q <= cfg_wdata;
		end
	end

	always_comb begin
		cnt_eff = (AW'(cnt_q) > AW'(MAX_ELEMENTS)) ? AW'(MAX_ELEMENTS) : AW'(cnt_q);
		lo_c    = (range_low == '0) ? AW'(1) : AW'(range_low);
		hi_c    = (AW'(range_high) > cnt_eff) ? cnt_eff : AW'(range_high);
		empty   = lo_c > hi_c;
		left_a  = AW'(MAX_ELEMENTS) + lo_c - AW'(1);
		right_a = AW'(MAX_ELEMENTS) + hi_c;
		leaf_a  = AW'(MAX_ELEMENTS) + AW'(position) - AW'(1);
		set_ok  = (position != '0) && (AW'(position) <= cnt_eff);

		in_stall   = clearing || q_full;
		push_value = value;
		if (action == rspu_pkg::ACTION_QUERY) begin
			push_cmd   = empty ? rspu_pkg::CMD_EMPTY : rspu_pkg::CMD_QUERY;
			push_left  = left_a[PW-1:0];
			push_right = right_a[PW-1:0];
			push       = in_valid && !in_stall;
		end else begin
			push_cmd   = rspu_pkg::CMD_SET;
			push_left  = leaf_a[PW-1:0];
			push_right = leaf_a[PW-1:0];
			// sets outside the active window are consumed and dropped
			push       = in_valid && !in_stall && set_ok;
		end
	end

endmodule

@@ rtl/rspu_queue.sv @@
// ----------------------------------------------------------------------------
// rspu_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module rspu_queue #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] push_data,
	output logic          full,
	input  logic          pop,
	output logic          q_valid,
	output logic [DW-1:0] pop_data
);

	logic [DW-1:0] mem_q [2];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	assign full     = cnt_q == 2'd2;
	assign q_valid  = cnt_q != 2'd0;
	assign pop_data = mem_q[rd_ptr_q];

endmodule

@@ rtl/rspu_back.sv @@
// ----------------------------------------------------------------------------
// rspu_back
// Tree memory and the level-by-level sequencer for updates and queries.
// ----------------------------------------------------------------------------
module rspu_back #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_valid,
	input  rspu_pkg::cmd_t                     q_cmd,
	input  logic [$clog2(2*MAX_ELEMENTS):0]    q_left,
	input  logic [$clog2(2*MAX_ELEMENTS):0]    q_right,
	input  logic [rspu_pkg::SUM_W-1:0]         q_value,
	output logic                               pop,
	output logic                               clearing,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [rspu_pkg::SUM_W-1:0]  range_sum
);

	localparam int NW = $clog2(2*MAX_ELEMENTS);
	localparam int PW = NW + 1;
	localparam int DEPTH = 2*MAX_ELEMENTS;

	rspu_pkg::state_t state_q, state_d;

	logic [rspu_pkg::SUM_W-1:0] mem [DEPTH];
	logic [rspu_pkg::SUM_W-1:0] rd_a_q, rd_b_q;
	logic [NW-1:0] raddr_a, raddr_b, waddr;
	logic [rspu_pkg::SUM_W-1:0] wdata;
	logic we;

	logic [NW-1:0] clr_q;
	logic [PW-1:0] node_q, lft_q, rgt_q;
	logic [rspu_pkg::SUM_W-1:0] cur_q, acc_q, res_q;
	logic take_a_q, take_b_q, out_valid_q;

	logic [PW-1:0] parent;
	logic [rspu_pkg::SUM_W-1:0] upd_sum, acc_d;
	logic out_load;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_a_q <= mem[raddr_a];
		rd_b_q <= mem[raddr_b];
	end

	always_comb begin
		parent  = node_q >> 1;
		upd_sum = cur_q + rd_a_q;
		acc_d   = acc_q + (take_a_q ? rd_a_q : '0) + (take_b_q ? rd_b_q : '0);
		out_load = 1'b0;
		pop      = 1'b0;
		we       = 1'b0;
		waddr    = clr_q;
		wdata    = '0;
		raddr_a  = lft_q[NW-1:0];
		raddr_b  = rgt_q[NW-1:0] - NW'(1);
		state_d  = state_q;
		case (state_q)
			rspu_pkg::ST_CLEAR: begin
				we = 1'b1;
				if (clr_q == NW'(DEPTH - 1)) state_d = rspu_pkg::ST_IDLE;
			end
			rspu_pkg::ST_IDLE: begin
				if (q_valid) begin
					pop = 1'b1;
					case (q_cmd)
						rspu_pkg::CMD_SET: begin
							we      = 1'b1;
							waddr   = q_left[NW-1:0];
							wdata   = q_value;
							raddr_a = q_left[NW-1:0] ^ NW'(1);
							state_d = rspu_pkg::ST_UPD;
						end
						rspu_pkg::CMD_QUERY: state_d = rspu_pkg::ST_QRY;
						default:             state_d = rspu_pkg::ST_OUT;
					endcase
				end
			end
			rspu_pkg::ST_UPD: begin
				// parent = running path sum + sibling read last cycle
				we      = 1'b1;
				waddr   = parent[NW-1:0];
				wdata   = upd_sum;
				raddr_a = parent[NW-1:0] ^ NW'(1);
				if (parent == PW'(1)) state_d = rspu_pkg::ST_IDLE;
			end
			rspu_pkg::ST_QRY: begin
				if (lft_q >= rgt_q) state_d = rspu_pkg::ST_OUT;
			end
			rspu_pkg::ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = rspu_pkg::ST_IDLE;
				end
			end
			default: state_d = rspu_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rspu_pkg::ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			take_a_q    <= 1'b0;
			take_b_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == rspu_pkg::ST_CLEAR) clr_q <= clr_q + NW'(1);
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			if (state_q == rspu_pkg::ST_QRY && lft_q < rgt_q) begin
				take_a_q <= lft_q[0];
				take_b_q <= rgt_q[0];
			end else begin
				take_a_q <= 1'b0;
				take_b_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rspu_pkg::ST_IDLE: begin
				node_q <= q_left;
				cur_q  <= q_value;
				lft_q  <= q_left;
				rgt_q  <= q_right;
				acc_q  <= '0;
				res_q  <= '0;
			end
			rspu_pkg::ST_UPD: begin
				node_q <= parent;
				cur_q  <= upd_sum;
			end
			rspu_pkg::ST_QRY: begin
				acc_q <= acc_d;
				res_q <= acc_d;
				lft_q <= (lft_q + PW'(lft_q[0])) >> 1;
				rgt_q <= rgt_q >> 1;
			end
			default: ;
		endcase
		if (out_load) range_sum <= res_q;
	end

	assign clearing  = state_q == rspu_pkg::ST_CLEAR;
	assign out_valid = out_valid_q;

	a_upd_node: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rspu_pkg::ST_UPD |-> node_q > PW'(1))
		else $error("update walk above root");
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == rspu_pkg::ST_OUT))
		else $error("result raised outside output state");
	a_clear_blk: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rspu_pkg::ST_CLEAR |-> !q_valid)
		else $error("request queued during clearing pass");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(take_a_q || take_b_q) |-> state_q == rspu_pkg::ST_QRY)
		else $error("node read pending outside query");

endmodule

@@ rtl/range_sum_point_update_tree.sv @@
// ----------------------------------------------------------------------------
// range_sum_point_update_tree
// Segment tree of wrapped 32-bit partial sums: point sets, range-sum queries.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  request  | in_valid / in_stall | action, position, value, range_low/high
//  result   | out_valid/out_stall | range_sum (one per query)
//  config   | cfg_we              | cfg_wdata -> element_count
//
//  Steps: a set is a dequeue and leaf write, then one tree level per cycle
//    through the single write port; a query is a dequeue, a walk up the tree
//    with two node reads per level, then one accumulate step and one output
//    step.
//  Reset: a clearing pass writes 2*MAX_ELEMENTS zero words, one per cycle;
//    in_stall stays high until it ends.
//  Stalls: a two-request queue decouples the front; the result register holds
//    while out_stall is high, and the back then waits in its output state.
// ----------------------------------------------------------------------------
module range_sum_point_update_tree #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rspu_pkg::IDX_W-1:0]        cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              action,
	input  logic [rspu_pkg::IDX_W-1:0]        position,
	input  logic signed [rspu_pkg::SUM_W-1:0] value,
	input  logic [rspu_pkg::IDX_W-1:0]        range_low,
	input  logic [rspu_pkg::IDX_W-1:0]        range_high,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [rspu_pkg::SUM_W-1:0] range_sum
);

	// node pointers carry one spare bit for the exclusive right bound
	localparam int PW = $clog2(2*MAX_ELEMENTS) + 1;
	localparam int DW = 2 + 2*PW + rspu_pkg::SUM_W;

	logic clearing, q_full, push, pop, q_valid;
	rspu_pkg::cmd_t push_cmd, q_cmd;
	logic [PW-1:0] push_left, push_right, q_left, q_right;
	logic [rspu_pkg::SUM_W-1:0] push_value, q_value;
	logic [DW-1:0] q_din, q_dout;

	rspu_front #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.position   (position),
		.value      (value),
		.range_low  (range_low),
		.range_high (range_high),
		.clearing   (clearing),
		.q_full     (q_full),
		.push       (push),
		.push_cmd   (push_cmd),
		.push_left  (push_left),
		.push_right (push_right),
		.push_value (push_value)
	);

	assign q_din = {push_cmd, push_left, push_right, push_value};

	rspu_queue #(.DW(DW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (q_din),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.pop_data  (q_dout)
	);

	assign q_cmd   = rspu_pkg::cmd_t'(q_dout[DW-1 -: 2]);
	assign q_left  = q_dout[DW-3 -: PW];
	assign q_right = q_dout[DW-3-PW -: PW];
	assign q_value = q_dout[rspu_pkg::SUM_W-1:0];

	rspu_back #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_left    (q_left),
		.q_right   (q_right),
		.q_value   (q_value),
		.pop       (pop),
		.clearing  (clearing),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.range_sum (range_sum)
	);

endmodule

@@ tb/sv/range_sum_point_update_tree_test.sv @@
// ----------------------------------------------------------------------------
// range_sum_point_update_tree_test
// Drives set and query requests into the sum tree at random pacing, tracks a
// flat copy of the element array and checks every returned range sum.
// ----------------------------------------------------------------------------
module range_sum_point_update_tree_test;

	localparam int MAXN     = 1024;
	localparam int WDOG_MAX = 20000;   // covers the clearing pass after reset
	localparam int SETTLE   = 40;      // a set may still be walking the tree

	typedef struct packed {
		logic                       act;
		logic [rspu_pkg::IDX_W-1:0] pos;
		logic [rspu_pkg::SUM_W-1:0] val;
		logic [rspu_pkg::IDX_W-1:0] lo;
		logic [rspu_pkg::IDX_W-1:0] hi;
	} req_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [rspu_pkg::IDX_W-1:0] cfg_wdata;
	logic in_valid, in_stall;
	logic action;
	logic [rspu_pkg::IDX_W-1:0] position, range_low, range_high;
	logic signed [rspu_pkg::SUM_W-1:0] value;
	logic out_valid, out_stall;
	logic signed [rspu_pkg::SUM_W-1:0] range_sum;

	range_sum_point_update_tree #(.MAX_ELEMENTS(MAXN)) u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .position(position), .value(value),
		.range_low(range_low), .range_high(range_high),
		.out_valid(out_valid), .out_stall(out_stall), .range_sum(range_sum)
	);

	// Flat model of the array: the tree only changes how sums are formed,
	// and wrapped addition is associative, so a plain loop gives the same word.
	logic [rspu_pkg::SUM_W-1:0] elems [1:MAXN];
	logic [rspu_pkg::IDX_W-1:0] count_reg;
	logic [rspu_pkg::SUM_W-1:0] sums_due [$];
	req_t                       pending [$];
	int                         errors;
	int                         wdog;
	bit                         in_noidle, out_noidle;
	bit                         timed_out;

	function automatic int active_n();
		return (count_reg > MAXN) ? MAXN : int'(count_reg);
	endfunction

	// Apply one accepted request to the array copy; queue a sum for queries
	task automatic predict_request(input req_t r);
		int n, lo, hi;
		logic [rspu_pkg::SUM_W-1:0] acc;
		n = active_n();
		if (r.act == rspu_pkg::ACTION_SET) begin
			if (r.pos >= 1 && r.pos <= n)
				elems[r.pos] = r.val;
		end else begin
			lo = (r.lo < 1) ? 1 : int'(r.lo);
			hi = (r.hi > n) ? n : int'(r.hi);
			acc = '0;
			for (int i = lo; i <= hi; i++)
				acc = acc + elems[i];
			sums_due.push_back(acc);
		end
	endtask

	function automatic req_t mk_set(int p, logic [rspu_pkg::SUM_W-1:0] v);
		req_t r;
		r = '0;
		r.act = rspu_pkg::ACTION_SET; r.pos = rspu_pkg::IDX_W'(p); r.val = v;
		// don't-care fields toggle too
		r.lo = rspu_pkg::IDX_W'($urandom); r.hi = rspu_pkg::IDX_W'($urandom);
		return r;
	endfunction

	function automatic req_t mk_query(int l, int h);
		req_t r;
		r = '0;
		r.act = rspu_pkg::ACTION_QUERY;
		r.lo = rspu_pkg::IDX_W'(l); r.hi = rspu_pkg::IDX_W'(h);
		r.pos = rspu_pkg::IDX_W'($urandom); r.val = $urandom;
		return r;
	endfunction

	// Mostly in-window positions, sometimes zero or past the count
	function automatic req_t rand_req(int n);
		int k, l, h;
		k = $urandom_range(0, 99);
		if (k < 50) begin
			if ($urandom_range(0, 19) == 0)
				return mk_set($urandom_range(0, 2047), $urandom);
			return mk_set($urandom_range(1, n), $urandom);
		end
		if ($urandom_range(0, 9) == 0) begin
			l = $urandom_range(0, 2047);
			h = $urandom_range(0, 2047);
		end else begin
			l = $urandom_range(1, n);
			h = $urandom_range(l, n);
			if ($urandom_range(0, 3) == 0)
				h = $urandom_range(l, l + 15 > n ? n : l + 15);
		end
		return mk_query(l, h);
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Driver: keeps the request steady while stalled, idles at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= 1'b0; position <= '0; value <= '0;
			range_low <= '0; range_high <= '0;
		end else if (in_valid && in_stall) begin
			// hold
		end else begin
			if (in_valid)
				predict_request(pending.pop_front());
			if (pending.size() > 0 && (in_noidle || $urandom_range(0, 99) >= 32)) begin
				in_valid   <= 1'b1;
				action     <= pending[0].act;
				position   <= pending[0].pos;
				value      <= pending[0].val;
				range_low  <= pending[0].lo;
				range_high <= pending[0].hi;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: random back-pressure, compares against oldest pending sum
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (sums_due.size() == 0) begin
					$error("unexpected range_sum %0d", range_sum);
					errors++;
				end else begin
					if (range_sum !== sums_due[0]) begin
						$error("range_sum: expected %0d, actual %0d",
							$signed(sums_due[0]), range_sum);
						errors++;
					end
					void'(sums_due.pop_front());
				end
			end
			out_stall <= out_noidle ? 1'b0 : ($urandom_range(0, 99) < 32);
		end
	end

	// Watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog >= WDOG_MAX && !timed_out) begin
			timed_out = 1'b1;
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Wait until the driver has sent all and every sum is back
	task automatic drain();
		while (pending.size() > 0 || in_valid || sums_due.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_count(int n);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= rspu_pkg::IDX_W'(n);
		@(posedge clk);
		cfg_we    <= 1'b0;
		count_reg = rspu_pkg::IDX_W'(n);
	endtask

	initial begin
		int n;
		errors = 0; wdog = 0; timed_out = 0;
		in_noidle = 0; out_noidle = 0;
		cfg_we = 0; cfg_wdata = '0;
		count_reg = rspu_pkg::RST_COUNT;
		for (int i = 1; i <= MAXN; i++)
			elems[i] = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, both actions, clamped and empty ranges
		pending.push_back(mk_query(1, MAXN));
		pending.push_back(mk_set(1, 32'h7FFF_FFFF));
		pending.push_back(mk_set(MAXN, 32'h8000_0000));
		pending.push_back(mk_set(2, 32'h0000_0001));
		pending.push_back(mk_set(0, 32'h1234_5678));       // ignored
		pending.push_back(mk_set(2047, 32'hFFFF_FFFF));    // ignored
		pending.push_back(mk_query(1, 2));                 // wraps
		pending.push_back(mk_query(0, 2047));              // both bounds clamp
		pending.push_back(mk_query(5, 4));                 // empty
		pending.push_back(mk_query(MAXN, MAXN));
		pending.push_back(mk_query(2047, 2047));           // empty after clamp
		pending.push_back(mk_set(513, 32'hFFFF_FFFF));
		pending.push_back(mk_query(512, 513));
		drain();

		// Several counts, extremes included; pause to drain between phases
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: n = 1;
				1: n = 0;
				2: n = 2;
				3: n = 37;
				4: n = 2047;
				5: n = 1023;
				6: n = 300;
				default: n = 1024;
			endcase
			write_count(n);
			in_noidle  = (ph == 5);
			out_noidle = (ph == 5);
			for (int k = 0; k < 110; k++)
				pending.push_back(rand_req(active_n() == 0 ? 1 : active_n()));
			drain();
		end
		in_noidle = 0; out_noidle = 0;

		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
